// ----- hw/rtl/circle_segment_collision_test_core_defines.svh -----
// Assertion macros shared by the collision test core RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef CIRCLE_SEGMENT_COLLISION_TEST_CORE_DEFINES_SVH
`define CIRCLE_SEGMENT_COLLISION_TEST_CORE_DEFINES_SVH
`ifndef SYNTH
`define CSC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CSC_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSC_ASSERT(lbl, clk, rst, prop, msg)
`define CSC_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/csc_pkg.sv -----
// Package for the circle/segment collision test core.
// Holds default widths, multiplier limb size and queue status type; no dependencies.
`timescale 1ns / 1ps
package csc_pkg;
  localparam int CSC_COORD_WIDTH = 32;
  localparam int CSC_LIMB_W      = 18;
  localparam int CSC_MUL_LAT     = 3;
  localparam int CSC_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } csc_qstat_t;
endpackage

// ----- hw/rtl/csc_mul.sv -----
// Pipelined signed multiplier built from limb partial products.
// Depends on csc_pkg for the limb width default.
`timescale 1ns / 1ps
module csc_mul #(
  parameter int N  = 33,
  parameter int LB = csc_pkg::CSC_LIMB_W
) (
  input  logic                  clk,
  input  logic signed [N-1:0]   a,
  input  logic signed [N-1:0]   b,
  output logic signed [2*N-1:0] p
);
  import csc_pkg::*;

  localparam int NL   = (N + LB - 1) / LB;
  localparam int PADW = NL * LB;

  logic [N-1:0]      ma, mb;
  logic [PADW-1:0]   pa, pb;
  logic [2*LB-1:0]   pp [NL][NL];
  logic [2*PADW-1:0] row [NL];
  logic [2*PADW-1:0] row_sum [NL];
  logic [2*PADW-1:0] tot;
  logic [2*N-1:0]    mag;
  logic              sign0, sign1;

  // Take magnitudes so that limbs are unsigned
  always_comb begin
    ma = a[N-1] ? (~a + 1'b1) : a;
    mb = b[N-1] ? (~b + 1'b1) : b;
    pa = PADW'(ma);
    pb = PADW'(mb);
  end

  // Stage one: limb products
  always_ff @(posedge clk) begin
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        pp[i][j] <= pa[i*LB +: LB] * pb[j*LB +: LB];
      end
    end
    sign0 <= a[N-1] ^ b[N-1];
  end

  // Stage two: sum each row of partial products
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      row_sum[i] = '0;
      for (int j = 0; j < NL; j++) begin
        row_sum[i] = row_sum[i] + ((2*PADW)'(pp[i][j]) << (j*LB));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NL; i++) begin
      row[i] <= row_sum[i] << (i*LB);
    end
    sign1 <= sign0;
  end

  // Stage three: sum rows and restore the sign
  always_comb begin
    tot = '0;
    for (int i = 0; i < NL; i++) begin
      tot = tot + row[i];
    end
    mag = tot[2*N-1:0];
  end

  always_ff @(posedge clk) begin
    p <= sign1 ? $signed(~mag + 1'b1) : $signed(mag);
  end
endmodule

// ----- hw/rtl/csc_front.sv -----
// Front end: takes a query, forms offsets, enlarged radius and degenerate flag.
// Depends on csc_pkg; feeds the transfer queue.
`timescale 1ns / 1ps
module csc_front #(
  parameter int W = csc_pkg::CSC_COORD_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [W-1:0]    center_x,
  input  logic signed [W-1:0]    center_y,
  input  logic [W-2:0]           radius,
  input  logic signed [W-1:0]    start_x,
  input  logic signed [W-1:0]    start_y,
  input  logic signed [W-1:0]    end_x,
  input  logic signed [W-1:0]    end_y,
  input  logic [W-2:0]           seg_width,
  input  csc_pkg::csc_qstat_t    qstat,
  output logic                   push,
  output logic [5*W+4:0]         item
);
  import csc_pkg::*;

  logic              valid, valid_next, take;
  logic signed [W:0] fx, fy, dx, dy;
  logic [W-1:0]      rr;
  logic              zl;

  assign busy = valid && qstat.full;
  assign take = start && !busy;
  assign push = valid && !qstat.full;
  assign item = {zl, rr, dy, dx, fy, fx};

  // Hold the item until the queue has room
  always_comb begin
    valid_next = take ? 1'b1 : (valid && qstat.full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Classify and form differences
  always_ff @(posedge clk) begin
    if (take) begin
      fx <= {start_x[W-1], start_x} - {center_x[W-1], center_x};
      fy <= {start_y[W-1], start_y} - {center_y[W-1], center_y};
      dx <= {end_x[W-1], end_x} - {start_x[W-1], start_x};
      dy <= {end_y[W-1], end_y} - {start_y[W-1], start_y};
      rr <= {1'b0, radius} + {1'b0, seg_width};
      zl <= (end_x == start_x) && (end_y == start_y);
    end
  end
endmodule

// ----- hw/rtl/csc_queue.sv -----
// Short transfer queue between front end and back end.
// Depends on csc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "circle_segment_collision_test_core_defines.svh"
module csc_queue #(
  parameter int DW    = 165,
  parameter int DEPTH = csc_pkg::CSC_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [DW-1:0]       wdata,
  input  logic                pop,
  output logic [DW-1:0]       rdata,
  output csc_pkg::csc_qstat_t qstat
);
  import csc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wr, rd;
  logic [AW:0]   count, count_next;

  assign qstat.full  = (count == (AW+1)'(DEPTH));
  assign qstat.empty = (count == '0);
  assign rdata       = mem[rd];

  // Track occupancy
  always_comb begin
    count_next = count + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr <= (wr == AW'(DEPTH-1)) ? '0 : wr + 1'b1;
      end
      if (pop) begin
        rd <= (rd == AW'(DEPTH-1)) ? '0 : rd + 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= wdata;
    end
  end

  `CSC_ASSERT(a_no_overflow, clk, rst, push |-> !qstat.full, "push into full queue")
  `CSC_ASSERT(a_no_underflow, clk, rst, pop |-> !qstat.empty, "pop from empty queue")
  `CSC_ASSERT(a_count_step, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1), "count did not advance")
endmodule

// ----- hw/rtl/csc_back.sv -----
// Back end: quadratic set-up, discriminant and root range checks.
// Depends on csc_pkg, csc_mul and the assertion macro header.
`timescale 1ns / 1ps
`include "circle_segment_collision_test_core_defines.svh"
module csc_back #(
  parameter int W = csc_pkg::CSC_COORD_WIDTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop,
  input  logic [5*W+4:0] item,
  output logic           done,
  output logic           collided
);
  import csc_pkg::*;

  localparam int CW    = 2*W + 4;
  localparam int DW    = 2*CW;
  localparam int TOTAL = 2*CSC_MUL_LAT + 3;

  logic signed [W:0]      fx, fy, dx, dy, rrs;
  logic                   zl;
  logic signed [2*W+1:0]  p_fxfx, p_fyfy, p_rr, p_dxdx, p_dydy, p_fxdx, p_fydy;
  logic [CSC_MUL_LAT-1:0] zl_d;
  logic signed [CW-1:0]   c_n, a_n, h_n, ah_n;
  logic signed [CW-1:0]   c, a, h, ah;
  logic                   zl1, zhit1;
  logic signed [DW-1:0]   p_hh, p_ac, p_ss;
  logic [3:0]             f_d [CSC_MUL_LAT];
  logic signed [DW-1:0]   d, hh, ss;
  logic [3:0]             f2;
  logic [TOTAL-1:0]       vshift;
  logic                   first, second, gen_hit;

  assign {zl, rrs[W-1:0], dy, dx, fy, fx} = item;
  assign rrs[W] = 1'b0;

  // Squares and cross products of the offsets
  csc_mul #(.N(W+1)) u_fxfx (.clk(clk), .a(fx),  .b(fx),  .p(p_fxfx));
  csc_mul #(.N(W+1)) u_fyfy (.clk(clk), .a(fy),  .b(fy),  .p(p_fyfy));
  csc_mul #(.N(W+1)) u_rr   (.clk(clk), .a(rrs), .b(rrs), .p(p_rr));
  csc_mul #(.N(W+1)) u_dxdx (.clk(clk), .a(dx),  .b(dx),  .p(p_dxdx));
  csc_mul #(.N(W+1)) u_dydy (.clk(clk), .a(dy),  .b(dy),  .p(p_dydy));
  csc_mul #(.N(W+1)) u_fxdx (.clk(clk), .a(fx),  .b(dx),  .p(p_fxdx));
  csc_mul #(.N(W+1)) u_fydy (.clk(clk), .a(fy),  .b(dy),  .p(p_fydy));

  // Advance the valid marker and side flags
  always_ff @(posedge clk) begin
    if (rst) begin
      vshift <= '0;
    end else begin
      vshift <= {vshift[TOTAL-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    zl_d <= {zl_d[CSC_MUL_LAT-2:0], zl};
  end

  // Quadratic coefficients
  always_comb begin
    c_n  = CW'(p_fxfx) + CW'(p_fyfy) - CW'(p_rr);
    a_n  = CW'(p_dxdx) + CW'(p_dydy);
    h_n  = CW'(p_fxdx) + CW'(p_fydy);
    ah_n = CW'(p_dxdx) + CW'(p_dydy) + CW'(p_fxdx) + CW'(p_fydy);
  end

  always_ff @(posedge clk) begin
    c     <= c_n;
    a     <= a_n;
    h     <= h_n;
    ah    <= ah_n;
    zl1   <= zl_d[CSC_MUL_LAT-1];
    zhit1 <= (c_n == '0) && (p_fyfy < p_rr);
  end

  // Discriminant terms and root bound squares
  csc_mul #(.N(CW)) u_hh (.clk(clk), .a(h),  .b(h),  .p(p_hh));
  csc_mul #(.N(CW)) u_ac (.clk(clk), .a(a),  .b(c),  .p(p_ac));
  csc_mul #(.N(CW)) u_ss (.clk(clk), .a(ah), .b(ah), .p(p_ss));

  always_ff @(posedge clk) begin
    f_d[0] <= {zl1, zhit1, (h <= 0), (ah >= 0)};
    for (int i = 1; i < CSC_MUL_LAT; i++) begin
      f_d[i] <= f_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    d  <= p_hh - p_ac;
    hh <= p_hh;
    ss <= p_ss;
    f2 <= f_d[CSC_MUL_LAT-1];
  end

  // Root range checks: flags are {degenerate, degenerate hit, h <= 0, a+h >= 0}
  always_comb begin
    first   = (f2[1] || (hh <= d)) && (f2[0] && (d <= ss));
    second  = (f2[1] && (d <= hh)) && (f2[0] || (ss <= d));
    gen_hit = (d > 0) && (first || second);
  end

  always_ff @(posedge clk) begin
    collided <= f2[3] ? f2[2] : gen_hit;
  end

  assign done = vshift[TOTAL-1];

  `CSC_ASSERT(a_pop_done, clk, rst, pop |-> ##TOTAL done, "result missing after pop")
  `CSC_ASSERT(a_done_pop, clk, rst, done |-> $past(pop, TOTAL), "result without pop")
  `CSC_ASSERT(a_tangent_miss, clk, rst, (vshift[TOTAL-2] && !f2[3] && d == 0) |=> !collided, "tangent line reported as hit")
endmodule

// ----- hw/rtl/circle_segment_collision_test_core.sv -----
// Circle versus thick segment collision test, top level.
// Depends on csc_pkg, csc_front, csc_queue and csc_back.
//
// Usage:
//   Drive the circle (center_x, center_y, radius) and the segment (start_x,
//   start_y, end_x, end_y, seg_width) in Q16.16 and raise start. A query is
//   taken at a clock edge with start high and busy low.
//   Each query gives one result: collided, shown for one cycle with done high.
//   A query passes through the front register, the two-entry queue and the
//   back end (two multiplier passes, coefficient, discriminant and compare
//   stages). One query is taken every cycle; busy only rises if the queue
//   fills, which the free-running back end never lets happen.
//   The receiver cannot stall: results leave on done whether or not used.
//   Reset (rst, synchronous) empties the queue and drops all queries in flight.
`timescale 1ns / 1ps
module circle_segment_collision_test_core #(
  parameter int COORD_WIDTH = csc_pkg::CSC_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic [COORD_WIDTH-2:0]        radius,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic [COORD_WIDTH-2:0]        seg_width,
  output logic                          done,
  output logic                          collided
);
  import csc_pkg::*;

  localparam int IW = 5*COORD_WIDTH + 5;

  csc_qstat_t    qstat;
  logic          push, pop;
  logic [IW-1:0] f_item, q_item;

  // Back end drains whenever the queue holds an item
  assign pop = !qstat.empty;

  csc_front #(.W(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .center_x(center_x), .center_y(center_y), .radius(radius),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .seg_width(seg_width), .qstat(qstat), .push(push), .item(f_item)
  );

  csc_queue #(.DW(IW), .DEPTH(CSC_QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(f_item),
    .pop(pop), .rdata(q_item), .qstat(qstat)
  );

  csc_back #(.W(COORD_WIDTH)) u_back (
    .clk(clk), .rst(rst), .pop(pop), .item(q_item),
    .done(done), .collided(collided)
  );
endmodule

// ----- tb/circle_segment_collision_test_core_tb.sv -----
// Testbench for circle_segment_collision_test_core: directed and random collision queries,
// each checked against an exact wide-integer predictor. Depends on csc_pkg and the core RTL.
`timescale 1ns / 1ps
module circle_segment_collision_test_core_tb;
  localparam int CW = csc_pkg::CSC_COORD_WIDTH;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [CW-2:0] len_t;
  typedef logic signed [255:0] wide_t;
  typedef struct {
    coord_t cx, cy, sx, sy, ex, ey;
    len_t r, w;
  } query_t;

  logic clk = 0, rst = 1, start = 0;
  logic busy, done, collided;
  coord_t center_x = '0, center_y = '0, start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  len_t radius = '0, seg_width = '0;

  query_t pending_queries[$];
  logic expected_hits[$];
  int errors = 0, stall_cycles = 0, hits_seen = 0, results_seen = 0;
  bit stimulus_done = 0, gap_free = 0, accepted = 0;

  circle_segment_collision_test_core u_dut (
    .clk, .rst, .start, .busy, .center_x, .center_y, .radius, .start_x, .start_y,
    .end_x, .end_y, .seg_width, .done, .collided
  );

  always #2 clk = ~clk;

  // Exact collision predictor on raw Q16.16 values
  function automatic logic hit_of(query_t q);
    wide_t fx, fy, dx, dy, rr, r2, fy2, c, a, h, d, nh, v1, v2;
    logic first, second;
    fx = wide_t'(q.sx) - wide_t'(q.cx);
    fy = wide_t'(q.sy) - wide_t'(q.cy);
    dx = wide_t'(q.ex) - wide_t'(q.sx);
    dy = wide_t'(q.ey) - wide_t'(q.sy);
    rr = wide_t'({1'b0, q.r}) + wide_t'({1'b0, q.w});
    r2 = rr * rr;
    fy2 = fy * fy;
    c = fx * fx + fy2 - r2;
    if (dx == 0 && dy == 0) return (c == 0) && (fy2 < r2);
    a = dx * dx + dy * dy;
    h = fx * dx + fy * dy;
    d = h * h - a * c;
    if (d <= 0) return 1'b0;
    nh = -h;
    v1 = a + h;
    v2 = nh - a;
    // root >= v holds when v <= 0 or v*v <= d; root <= v needs v >= 0 and d <= v*v
    first = (h <= 0 || h * h <= d) && (v1 >= 0 && d <= v1 * v1);
    second = (nh >= 0 && d <= nh * nh) && (v2 <= 0 || v2 * v2 <= d);
    return first || second;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom());
      1: return coord_t'($urandom_range(0, 32'h000A_0000)) - coord_t'(32'h0005_0000);
      default: return coord_t'($urandom_range(0, 64)) - coord_t'(32);
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int mode;
    mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1);
    q.cx = rand_coord(mode); q.cy = rand_coord(mode);
    q.sx = rand_coord(mode); q.sy = rand_coord(mode);
    q.ex = rand_coord(mode); q.ey = rand_coord(mode);
    q.r = mode == 0 ? len_t'($urandom()) : len_t'($urandom_range(0, mode == 1 ? 32'h0003_0000 : 24));
    q.w = mode == 0 ? len_t'($urandom()) : len_t'($urandom_range(0, mode == 1 ? 32'h0001_0000 : 8));
    // force horizontal, vertical or point segments now and then
    case ($urandom_range(0, 7))
      0: q.ey = q.sy;
      1: q.ex = q.sx;
      2: begin q.ex = q.sx; q.ey = q.sy; end
      default: ;
    endcase
    return q;
  endfunction

  function automatic query_t mk(int cx, int cy, int r, int sx, int sy, int ex, int ey, int w);
    query_t q;
    q.cx = coord_t'(cx); q.cy = coord_t'(cy); q.r = len_t'(r);
    q.sx = coord_t'(sx); q.sy = coord_t'(sy); q.ex = coord_t'(ex); q.ey = coord_t'(ey);
    q.w = len_t'(w);
    return q;
  endfunction

  // Fill the query queue; the driver stops once everything has been sent
  initial begin
    query_t q;
    pending_queries.push_back(mk(0, 0, 5, -10, 0, 10, 0, 0));   // horizontal crossing
    pending_queries.push_back(mk(0, 0, 5, 0, -10, 0, 10, 0));   // vertical crossing
    pending_queries.push_back(mk(0, 0, 5, -10, -9, 10, 11, 0)); // sloped crossing
    pending_queries.push_back(mk(0, 0, 5, -10, 5, 10, 5, 0));   // tangent
    pending_queries.push_back(mk(0, 0, 3, -10, 3, 10, 3, 2));   // crossing through width
    pending_queries.push_back(mk(0, 0, 50, -1, 0, 1, 1, 0));    // segment inside circle
    pending_queries.push_back(mk(0, 0, 5, 20, 0, 30, 0, 0));    // line hits, segment misses
    pending_queries.push_back(mk(0, 0, 5, 3, 4, 3, 4, 0));      // point on circle
    pending_queries.push_back(mk(0, 0, 5, 0, 5, 0, 5, 0));      // point at topmost
    pending_queries.push_back(mk(0, 0, 5, 1, 1, 1, 1, 0));      // point inside
    pending_queries.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));      // all zero
    pending_queries.push_back(mk(0, 0, 5, 0, 0, 0, 9, 0));      // one end inside
    q = mk(0, 0, 0, 0, 0, 0, 0, 0);
    q.cx = {1'b1, {(CW-1){1'b0}}}; q.cy = {1'b0, {(CW-1){1'b1}}};
    q.sx = {1'b0, {(CW-1){1'b1}}}; q.sy = {1'b1, {(CW-1){1'b0}}};
    q.ex = {1'b1, {(CW-1){1'b0}}}; q.ey = {1'b0, {(CW-1){1'b1}}};
    q.r = '1; q.w = '1;
    pending_queries.push_back(q);                               // widest sums
    q.r = '1; q.w = '0; q.cx = '1; q.cy = '0;
    pending_queries.push_back(q);
    q.sx = {1'b1, {(CW-1){1'b0}}}; q.ex = {1'b0, {(CW-1){1'b1}}}; q.sy = '0; q.ey = '0;
    q.r = '0; q.w = '1;
    pending_queries.push_back(q);
    repeat (550) pending_queries.push_back(rand_query());
  end

  // Reset and the closing check
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 0;
    wait (stimulus_done && expected_hits.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d collision queries (%0d hits),", results_seen, hits_seen);
    $display("covering horizontal, vertical, sloped and point segments.");
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("circle_segment_collision_test_core verification clean");
    end else begin
      $display("circle_segment_collision_test_core verification failed");
    end
    $finish;
  end

  // Driver: present queries at the falling edge, with random gaps outside a gap-free stretch
  always @(negedge clk) begin
    if (!rst) begin
      if (accepted) begin
        void'(pending_queries.pop_front());
      end
      if (pending_queries.size() > 0 && (gap_free || $urandom_range(0, 99) >= 17)) begin
        center_x <= pending_queries[0].cx; center_y <= pending_queries[0].cy;
        radius <= pending_queries[0].r; seg_width <= pending_queries[0].w;
        start_x <= pending_queries[0].sx; start_y <= pending_queries[0].sy;
        end_x <= pending_queries[0].ex; end_y <= pending_queries[0].ey;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
      if (pending_queries.size() == 0) stimulus_done <= 1'b1;
      gap_free <= pending_queries.size() > 150 && pending_queries.size() < 300;
    end
  end

  // Monitor: record transfers, check results at the rising edge and stop the run on a stall
  always @(posedge clk) begin
    if (!rst) begin
      accepted <= start && !busy;
      if (start && !busy) begin
        expected_hits.push_back(hit_of('{center_x, center_y, start_x, start_y, end_x, end_y,
                                         radius, seg_width}));
        stall_cycles <= 0;
      end else if (done) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (done) begin
        results_seen <= results_seen + 1;
        if (expected_hits.size() == 0) begin
          $error("collided: result with no query outstanding, actual %0b", collided);
          errors <= errors + 1;
        end else begin
          if (collided !== expected_hits[0]) begin
            $error("collided: expected %0b, actual %0b", expected_hits[0], collided);
            errors <= errors + 1;
          end
          if (expected_hits[0]) hits_seen <= hits_seen + 1;
          void'(expected_hits.pop_front());
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("circle_segment_collision_test_core verification failed");
        $finish;
      end
    end
  end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/csc_pkg.sv
hw/rtl/csc_mul.sv
hw/rtl/csc_front.sv
hw/rtl/csc_queue.sv
hw/rtl/csc_back.sv
hw/rtl/circle_segment_collision_test_core.sv
tb/circle_segment_collision_test_core_tb.sv
